/* rtl/vpa_pkg.sv */
// shared types and constants of the velocity pi controller
`default_nettype none

package vpa_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SPEED_W    = 16;
    localparam int CFG15_W    = 15;
    localparam int GAIN_W     = 16;
    localparam int CMD_W      = 11;

    localparam int ERR_W      = 32;
    localparam int PROD_W     = ERR_W + GAIN_W;
    localparam int REF_MAG_W  = 31;
    localparam int TERM_W     = PROD_W - 15;
    localparam int SUM_W      = TERM_W + 1;

    localparam logic signed [PROD_W-1:0] Q15_HALF = PROD_W'(16384);
    localparam logic signed [ERR_W-1:0]  ERR_SAT  = ERR_W'(32767);

    localparam logic [CFG15_W-1:0] MAX_SPEED_RST  = CFG15_W'(1000);
    localparam logic [CFG15_W-1:0] TORQUE_MAX_RST = CFG15_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SPEED,
        REG_PROP_GAIN,
        REG_INTEGRAL_GAIN,
        REG_INTEGRAL_LIMIT,
        REG_TORQUE_MAX
    } cfg_reg_t;

endpackage

`default_nettype wire

/* rtl/vpa_mul_serial.sv */
// bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier
`default_nettype none

module vpa_mul_serial #(
    parameter int A_W = 32,
    parameter int B_W = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [A_W-1:0]   a,
    input  wire logic [B_W-1:0]          b,
    output logic                         done,
    output logic signed [A_W+B_W-1:0]    product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic signed [A_W-1:0] a_reg;
    logic [B_W-1:0]        b_reg;
    logic signed [P_W-1:0] acc_reg;
    logic signed [P_W-1:0] acc_next;
    logic signed [P_W-1:0] addend;

    assign addend   = b_reg[B_W-1] ? P_W'(a_reg) : '0;
    assign acc_next = $signed({acc_reg[P_W-2:0], 1'b0}) + addend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                b_reg   <= {b_reg[B_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

/* rtl/vpa_div_serial.sv */
// bit-serial restoring divider by a fixed divisor, one quotient bit per cycle
`default_nettype none

module vpa_div_serial #(
    parameter int N_W     = 31,
    parameter int DIVISOR = 1000
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [N_W-1:0]  numer,
    output logic                 done,
    output logic [N_W-1:0]       quot
);

    localparam int R_W   = $clog2(DIVISOR + 1);
    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(N_W - 1);
    localparam logic [R_W:0]     DIV_C = (R_W + 1)'(DIVISOR);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [R_W-1:0]   rem_reg;
    logic [N_W-1:0]   num_reg;
    logic [R_W:0]     trial;
    logic             fits;
    logic [R_W:0]     diff;

    assign trial = {rem_reg, num_reg[N_W-1]};
    assign fits  = (trial >= DIV_C);
    assign diff  = trial - DIV_C;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                num_reg  <= numer;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[R_W-1:0] : trial[R_W-1:0];
                num_reg <= {num_reg[N_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

`default_nettype wire

/* rtl/velocity_pi_antiwindup_core.sv */
// velocity pi controller with conditional-integration anti-windup, top level
//
//  channel  | direction | transfer when     | payload
//  ---------+-----------+-------------------+------------------------------------------
//  s_       | in        | s_valid & s_ready | velocity_setpoint, measured_speed, enable
//  m_       | out       | m_valid & m_ready | torque_command, speed_error, saturated
//  cfg_     | in        | cfg_wr_en         | cfg_index, cfg_data
//
//  an enabled tick runs the reference product, then the bit-serial divide by
//  FULL_SCALE_CMD, then the two gain products run side by side, and last the clamping
//  and the integrator update; a disabled tick goes straight to the output step.
//  reset clears the controller state and loads the register defaults.
//  a new item is taken once the sequencer is idle, even while the last result waits.
//  a stalled result holds the sequencer in its last step until the output frees.
`default_nettype none

module velocity_pi_antiwindup_core #(
    parameter int FULL_SCALE_CMD = 1000
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_wr_en,
    input  wire logic [vpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [vpa_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [vpa_pkg::SPEED_W-1:0] s_velocity_setpoint,
    input  wire logic signed [vpa_pkg::SPEED_W-1:0] s_measured_speed,
    input  wire logic                               s_enable,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [vpa_pkg::CMD_W-1:0]        m_torque_command,
    output logic signed [vpa_pkg::SPEED_W-1:0]      m_speed_error,
    output logic                                    m_saturated
);

    import vpa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REFMUL,
        ST_DIV,
        ST_GAIN,
        ST_INTEG,
        ST_CMD,
        ST_OUT
    } state_t;

    localparam logic [CFG15_W-1:0] FSC_C = CFG15_W'(FULL_SCALE_CMD);

    state_t state_reg;

    logic [CFG15_W-1:0] max_speed_reg;
    logic [GAIN_W-1:0]  prop_gain_reg;
    logic [GAIN_W-1:0]  integral_gain_reg;
    logic [CFG15_W-1:0] integral_limit_reg;
    logic [CFG15_W-1:0] torque_max_reg;

    logic signed [SPEED_W-1:0] integ_reg;
    logic signed [SPEED_W-1:0] cand_reg;
    logic                      wind_reg;
    logic signed [SPEED_W-1:0] meas_reg;
    logic                      ref_neg_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [TERM_W-1:0]  p_reg;
    logic signed [TERM_W-1:0]  di_reg;

    logic signed [CMD_W-1:0]   res_cmd_reg;
    logic signed [SPEED_W-1:0] res_err_reg;
    logic                      res_sat_reg;

    logic                      m_valid_reg;
    logic signed [CMD_W-1:0]   m_cmd_reg;
    logic signed [SPEED_W-1:0] m_err_reg;
    logic                      m_sat_reg;

    logic                      accept;
    logic                      active;
    logic                      p_start;
    logic                      i_start;
    logic signed [ERR_W-1:0]   p_a;
    logic [GAIN_W-1:0]         p_b;
    logic                      p_done;
    logic                      i_done;
    logic signed [PROD_W-1:0]  p_prod;
    logic signed [PROD_W-1:0]  i_prod;
    logic signed [PROD_W-1:0]  p_round;
    logic signed [PROD_W-1:0]  i_round;
    logic signed [PROD_W-1:0]  ref_mag_full;
    logic                      div_start;
    logic                      div_done;
    logic [REF_MAG_W-1:0]      div_quot;
    logic signed [ERR_W-1:0]   ref_val;
    logic signed [ERR_W-1:0]   err_calc;

    logic [CFG15_W-1:0]        tl;
    logic signed [SUM_W-1:0]   tl_pos;
    logic signed [SUM_W-1:0]   ilim_pos;
    logic signed [SUM_W-1:0]   integ_sum;
    logic signed [SPEED_W-1:0] integ_clamp;
    logic signed [SUM_W-1:0]   raw;
    logic signed [SUM_W-1:0]   cmd;
    logic                      sat;
    logic                      withdraw;
    logic signed [SPEED_W-1:0] err_out;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign active  = s_enable && (max_speed_reg != '0);

    // shared multiplier: reference product first, then proportional product
    assign p_start   = (accept && active) || (state_reg == ST_DIV && div_done);
    assign i_start   = (state_reg == ST_DIV) && div_done;
    assign p_a       = (state_reg == ST_IDLE) ? ERR_W'(s_velocity_setpoint) : err_calc;
    assign p_b       = (state_reg == ST_IDLE) ? GAIN_W'(max_speed_reg) : prop_gain_reg;

    vpa_mul_serial #(
        .A_W (ERR_W),
        .B_W (GAIN_W)
    ) u_mul_p (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (p_start),
        .a       (p_a),
        .b       (p_b),
        .done    (p_done),
        .product (p_prod)
    );

    vpa_mul_serial #(
        .A_W (ERR_W),
        .B_W (GAIN_W)
    ) u_mul_i (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (i_start),
        .a       (err_calc),
        .b       (integral_gain_reg),
        .done    (i_done),
        .product (i_prod)
    );

    assign ref_mag_full = p_prod[PROD_W-1] ? -p_prod : p_prod;
    assign div_start    = (state_reg == ST_REFMUL) && p_done;

    vpa_div_serial #(
        .N_W     (REF_MAG_W),
        .DIVISOR (FULL_SCALE_CMD)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (ref_mag_full[REF_MAG_W-1:0]),
        .done    (div_done),
        .quot    (div_quot)
    );

    // truncation toward zero: divide the magnitude, then restore the sign
    assign ref_val  = ref_neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    assign err_calc = ref_val - ERR_W'(meas_reg);

    // round half up, floor shift by 15
    assign p_round = p_prod + Q15_HALF;
    assign i_round = i_prod + Q15_HALF;

    // torque limit: zero means full scale, capped at full scale
    assign tl       = (torque_max_reg == '0 || torque_max_reg > FSC_C) ? FSC_C : torque_max_reg;
    assign tl_pos   = $signed({{(SUM_W - CFG15_W){1'b0}}, tl});
    assign ilim_pos = $signed({{(SUM_W - CFG15_W){1'b0}}, integral_limit_reg});

    assign integ_sum = SUM_W'(integ_reg) + SUM_W'(di_reg);

    always_comb begin
        if (integ_sum > ilim_pos) begin
            integ_clamp = SPEED_W'(ilim_pos);
        end else if (integ_sum < -ilim_pos) begin
            integ_clamp = SPEED_W'(-ilim_pos);
        end else begin
            integ_clamp = integ_sum[SPEED_W-1:0];
        end
    end

    assign raw = SUM_W'(p_reg) + SUM_W'(cand_reg);

    always_comb begin
        if (raw > tl_pos) begin
            cmd = tl_pos;
        end else if (raw < -tl_pos) begin
            cmd = -tl_pos;
        end else begin
            cmd = raw;
        end
    end

    assign sat      = (cmd != raw);
    assign withdraw = sat && !wind_reg &&
                      ((cmd > 0 && err_reg > 0) || (cmd < 0 && err_reg < 0));

    always_comb begin
        if (err_reg > ERR_SAT) begin
            err_out = SPEED_W'(ERR_SAT);
        end else if (err_reg < -ERR_SAT) begin
            err_out = SPEED_W'(-ERR_SAT);
        end else begin
            err_out = err_reg[SPEED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_valid_reg        <= 1'b0;
            integ_reg          <= '0;
            wind_reg           <= 1'b0;
            max_speed_reg      <= MAX_SPEED_RST;
            prop_gain_reg      <= '0;
            integral_gain_reg  <= '0;
            integral_limit_reg <= '0;
            torque_max_reg     <= TORQUE_MAX_RST;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_MAX_SPEED:      max_speed_reg      <= cfg_data[CFG15_W-1:0];
                    REG_PROP_GAIN:      prop_gain_reg      <= cfg_data[GAIN_W-1:0];
                    REG_INTEGRAL_GAIN:  integral_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[CFG15_W-1:0];
                    REG_TORQUE_MAX:     torque_max_reg     <= cfg_data[CFG15_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        meas_reg <= s_measured_speed;
                        if (active) begin
                            state_reg <= ST_REFMUL;
                        end else begin
                            integ_reg   <= '0;
                            res_cmd_reg <= '0;
                            res_err_reg <= '0;
                            res_sat_reg <= 1'b0;
                            state_reg   <= ST_OUT;
                        end
                    end
                end
                ST_REFMUL: begin
                    if (p_done) begin
                        ref_neg_reg <= p_prod[PROD_W-1];
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        err_reg   <= err_calc;
                        state_reg <= ST_GAIN;
                    end
                end
                ST_GAIN: begin
                    if (p_done) begin
                        p_reg     <= p_round[PROD_W-1:15];
                        di_reg    <= i_round[PROD_W-1:15];
                        state_reg <= ST_INTEG;
                    end
                end
                ST_INTEG: begin
                    cand_reg  <= integ_clamp;
                    wind_reg  <= 1'b0;
                    state_reg <= ST_CMD;
                end
                ST_CMD: begin
                    if (withdraw) begin
                        // drop this tick's increment and recompute
                        cand_reg <= integ_reg;
                        wind_reg <= 1'b1;
                    end else begin
                        integ_reg   <= cand_reg;
                        res_cmd_reg <= cmd[CMD_W-1:0];
                        res_err_reg <= err_out;
                        res_sat_reg <= sat;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_cmd_reg   <= res_cmd_reg;
                        m_err_reg   <= res_err_reg;
                        m_sat_reg   <= res_sat_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_torque_command = m_cmd_reg;
    assign m_speed_error    = m_err_reg;
    assign m_saturated      = m_sat_reg;

    a_gain_done_together: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GAIN) && p_done |-> i_done)
        else $error("gain products finished apart");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its step");

    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        p_done |-> (state_reg == ST_REFMUL || state_reg == ST_GAIN))
        else $error("multiplier finished outside its steps");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && (!m_valid_reg || m_ready) |=> m_valid && s_ready)
        else $error("result not presented after final step");

    a_single_withdraw: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMD) && wind_reg |=> state_reg == ST_OUT)
        else $error("anti-windup recompute repeated");

endmodule

`default_nettype wire
